@@ rtl/core/ggx_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggx_pkg
// Shared constants for the GGX microfacet evaluator pipeline.
// ----------------------------------------------------------------------------
package ggx_pkg;

  // fixed-point constants
  localparam logic [14:0] ONE_Q14     = 15'd16384;
  localparam logic [28:0] ONE_Q28     = 29'd268435456;
  localparam logic [30:0] INV_PI_Q32  = 31'd1367130551;
  localparam logic [31:0] SAT32       = 32'hFFFF_FFFF;
  localparam logic [16:0] ALPHA_ONE   = 17'd65536;
  localparam logic [16:0] ALPHA_RESET = 17'd6554;

  // register map (word index taken from paddr[2])
  localparam logic CFG_IDX_ALPHA = 1'b0;

  // pipeline geometry
  localparam int SQRT_STEPS    = 31;  // 62-bit radicand, 31-bit root
  localparam int NDF_DIV_STEPS = 46;  // quotient bits below the saturation point
  localparam int G1_DIV_STEPS  = 18;  // G1 quotient bits
  localparam int NDF_LAT       = 5 + NDF_DIV_STEPS + 2;
  localparam int PIPE_DEPTH    = 4 + SQRT_STEPS + G1_DIV_STEPS + 1;

endpackage

@@ rtl/core/ggx_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggx_isqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module ggx_isqrt (
  input  logic        clk,
  input  logic        ce,
  input  logic [61:0] num,
  output logic [30:0] root
);

  logic [32:0] rem_r [1:ggx_pkg::SQRT_STEPS];
  logic [30:0] rt_r  [1:ggx_pkg::SQRT_STEPS];
  logic [61:0] n_r   [1:ggx_pkg::SQRT_STEPS];

  for (genvar k = 1; k <= ggx_pkg::SQRT_STEPS; k++) begin : g_step
    logic [32:0] rem_p;
    logic [30:0] rt_p;
    logic [61:0] n_p;
    logic [34:0] rs;
    logic [34:0] tr;

    if (k == 1) begin : g_first
      assign rem_p = '0;
      assign rt_p  = '0;
      assign n_p   = num;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign rt_p  = rt_r[k-1];
      assign n_p   = n_r[k-1];
    end

    // bring down two radicand bits, try root bit one
    assign rs = {rem_p, n_p[61:60]};
    assign tr = {2'b00, rt_p, 2'b01};

    always_ff @(posedge clk) begin
      if (ce) begin
        if (rs >= tr) begin
          rem_r[k] <= 33'(rs - tr);
          rt_r[k]  <= {rt_p[29:0], 1'b1};
        end else begin
          rem_r[k] <= rs[32:0];
          rt_r[k]  <= {rt_p[29:0], 1'b0};
        end
        n_r[k] <= {n_p[59:0], 2'b00};
      end
    end
  end

  assign root = rt_r[ggx_pkg::SQRT_STEPS];

endmodule

@@ rtl/core/ggx_ndf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggx_ndf
// GGX density and sample pdf pipeline with a bit-per-stage divider.
// ----------------------------------------------------------------------------
module ggx_ndf (
  input  logic               clk,
  input  logic               ce,
  input  logic signed [15:0] m_z,      // stage 0
  input  logic [32:0]        a2,       // stage 1
  output logic [31:0]        density,  // stage NDF_LAT
  output logic [31:0]        sample_pdf
);

  // stage 1
  logic [14:0] c_w;
  logic [29:0] csq_w;
  logic [14:0] c1_r;
  logic [28:0] c2_1_r;
  logic        mpos1_r;

  assign c_w = (m_z > 16'sd16384) ? ggx_pkg::ONE_Q14 :
               (m_z < 16'sd1)     ? 15'd1 : m_z[14:0];
  assign csq_w = c_w * c_w;

  always_ff @(posedge clk) begin
    if (ce) begin
      c1_r    <= c_w;
      c2_1_r  <= csq_w[28:0];
      mpos1_r <= (m_z > 16'sd0);
    end
  end

  // stage 2
  logic [61:0] cs_w;
  logic [63:0] n_w;
  logic [61:0] cs2_r;
  logic [63:0] n2_r;
  logic [28:0] c2_2_r;
  logic [14:0] c2_r;
  logic        mpos2_r;

  assign cs_w = c2_1_r * a2;
  assign n_w  = a2 * ggx_pkg::INV_PI_Q32;

  always_ff @(posedge clk) begin
    if (ce) begin
      cs2_r   <= cs_w;
      n2_r    <= n_w;
      c2_2_r  <= c2_1_r;
      c2_r    <= c1_r;
      mpos2_r <= mpos1_r;
    end
  end

  // stage 3: rounded denominator root
  logic [28:0] wd_w;
  logic [61:0] s_w;
  logic [30:0] t3_r;
  logic [63:0] n3_r;
  logic [14:0] c3_r;
  logic        mpos3_r;

  assign wd_w = ggx_pkg::ONE_Q28 - c2_2_r;
  assign s_w  = cs2_r + {1'b0, wd_w, 32'b0} + 62'd536870912;

  always_ff @(posedge clk) begin
    if (ce) begin
      t3_r    <= s_w[60:30];
      n3_r    <= n2_r;
      c3_r    <= c2_r;
      mpos3_r <= mpos2_r;
    end
  end

  // stage 4: squared denominator
  logic [61:0] tsq_w;
  logic [60:0] t2_4_r;
  logic [63:0] n4_r;
  logic [14:0] c4_r;
  logic        mpos4_r;

  assign tsq_w = t3_r * t3_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      t2_4_r  <= tsq_w[60:0];
      n4_r    <= n3_r;
      c4_r    <= c3_r;
      mpos4_r <= mpos3_r;
    end
  end

  // stage 5: saturation test covers a zero denominator too
  logic [60:0] r5_r;
  logic [45:0] xl5_r;
  logic [60:0] t2_5_r;
  logic [14:0] c5_r;
  logic        mpos5_r;
  logic        sat5_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      sat5_r  <= ({31'b0, n4_r[63:34]} >= t2_4_r);
      r5_r    <= {31'b0, n4_r[63:34]};
      xl5_r   <= {n4_r[33:0], 12'b0};
      t2_5_r  <= t2_4_r;
      c5_r    <= c4_r;
      mpos5_r <= mpos4_r;
    end
  end

  // restoring divider
  logic [60:0] r_r    [1:ggx_pkg::NDF_DIV_STEPS];
  logic [45:0] xl_r   [1:ggx_pkg::NDF_DIV_STEPS];
  logic [45:0] q_r    [1:ggx_pkg::NDF_DIV_STEPS];
  logic [60:0] t2_r   [1:ggx_pkg::NDF_DIV_STEPS];
  logic [14:0] c_r    [1:ggx_pkg::NDF_DIV_STEPS];
  logic        mpos_r [1:ggx_pkg::NDF_DIV_STEPS];
  logic        sat_r  [1:ggx_pkg::NDF_DIV_STEPS];

  for (genvar k = 1; k <= ggx_pkg::NDF_DIV_STEPS; k++) begin : g_div
    logic [60:0] r_p;
    logic [45:0] xl_p;
    logic [45:0] q_p;
    logic [60:0] t2_p;
    logic [14:0] c_p;
    logic        mpos_p;
    logic        sat_p;
    logic [61:0] rs;

    if (k == 1) begin : g_first
      assign r_p    = r5_r;
      assign xl_p   = xl5_r;
      assign q_p    = '0;
      assign t2_p   = t2_5_r;
      assign c_p    = c5_r;
      assign mpos_p = mpos5_r;
      assign sat_p  = sat5_r;
    end else begin : g_next
      assign r_p    = r_r[k-1];
      assign xl_p   = xl_r[k-1];
      assign q_p    = q_r[k-1];
      assign t2_p   = t2_r[k-1];
      assign c_p    = c_r[k-1];
      assign mpos_p = mpos_r[k-1];
      assign sat_p  = sat_r[k-1];
    end

    assign rs = {r_p, xl_p[45]};

    always_ff @(posedge clk) begin
      if (ce) begin
        if (rs >= {1'b0, t2_p}) begin
          r_r[k] <= 61'(rs - {1'b0, t2_p});
          q_r[k] <= {q_p[44:0], 1'b1};
        end else begin
          r_r[k] <= rs[60:0];
          q_r[k] <= {q_p[44:0], 1'b0};
        end
        xl_r[k]   <= {xl_p[44:0], 1'b0};
        t2_r[k]   <= t2_p;
        c_r[k]    <= c_p;
        mpos_r[k] <= mpos_p;
        sat_r[k]  <= sat_p;
      end
    end
  end

  // stage NDF_LAT-1: clamp density, scale by cos theta
  logic [45:0] q_w;
  logic [60:0] pq_w;
  logic [31:0] dens_w;
  logic [31:0] dens_r;
  logic [60:0] pq_r;
  logic        mposp_r;
  logic        satp_r;

  assign q_w    = q_r[ggx_pkg::NDF_DIV_STEPS];
  assign pq_w   = q_w * c_r[ggx_pkg::NDF_DIV_STEPS];
  assign dens_w = !mpos_r[ggx_pkg::NDF_DIV_STEPS] ? 32'd0 :
                  (sat_r[ggx_pkg::NDF_DIV_STEPS] || (|q_w[45:32])) ? ggx_pkg::SAT32 :
                  q_w[31:0];

  always_ff @(posedge clk) begin
    if (ce) begin
      dens_r  <= dens_w;
      pq_r    <= pq_w;
      mposp_r <= mpos_r[ggx_pkg::NDF_DIV_STEPS];
      satp_r  <= sat_r[ggx_pkg::NDF_DIV_STEPS];
    end
  end

  // stage NDF_LAT
  logic [31:0] pdf_w;
  logic [31:0] dens_o_r;
  logic [31:0] pdf_o_r;

  assign pdf_w = !mposp_r ? 32'd0 :
                 (satp_r || (|pq_r[60:46])) ? ggx_pkg::SAT32 : pq_r[45:14];

  always_ff @(posedge clk) begin
    if (ce) begin
      dens_o_r <= dens_r;
      pdf_o_r  <= pdf_w;
    end
  end

  assign density    = dens_o_r;
  assign sample_pdf = pdf_o_r;

endmodule

@@ rtl/core/ggx_microfacet_evaluator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggx_microfacet_evaluator_unit
// GGX normal distribution, sample pdf and Smith masking-shadowing per item.
// ----------------------------------------------------------------------------
// Fully pipelined: one item is taken per clock and its result appears after
// PIPE_DEPTH (54) register stages. The depth is set by the Smith path: dot
// products and radicand (3 stages), a 31-stage square root, a divisor stage,
// then an 18-stage divider and the final product; the density path (53
// stages, 46 of them a bit-per-stage divider) runs beside it and feeds the
// output stage directly. The whole pipe holds while a result waits at the
// output, so nothing is lost or repeated under backpressure.
// alpha is read at entry and should be written only while the pipe is empty.
module ggx_microfacet_evaluator_unit (
  input  logic         clk,
  input  logic         rst_n,
  // slave stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // m_x, m_y, m_z, wi_x, wi_y, wi_z, wo_x, wo_y, wo_z (16 bits each)
  input  logic [143:0] in_tdata,
  // master stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // density[31:0], sample_pdf[63:32], shadowing[80:64], zero fill
  output logic [87:0]  out_tdata,
  // config port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  // config register
  logic [16:0] alpha_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ggx_pkg::ALPHA_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 (cfg_paddr[2] == ggx_pkg::CFG_IDX_ALPHA)) begin
      alpha_r <= cfg_pwdata[16:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == ggx_pkg::CFG_IDX_ALPHA) ? {15'b0, alpha_r} : 32'd0;

  // pipe control
  logic ce;
  logic vld_r [1:ggx_pkg::PIPE_DEPTH];

  assign ce        = !vld_r[ggx_pkg::PIPE_DEPTH] || out_tready;
  assign in_tready = ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= ggx_pkg::PIPE_DEPTH; k++) vld_r[k] <= 1'b0;
    end else if (ce) begin
      vld_r[1] <= in_tvalid;
      for (int k = 2; k <= ggx_pkg::PIPE_DEPTH; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // shared stage 1: alpha squared
  logic [16:0] a_w;
  logic [33:0] asq_w;
  logic [32:0] a2_1_r;

  assign a_w   = alpha_r[16] ? ggx_pkg::ALPHA_ONE : alpha_r;
  assign asq_w = a_w * a_w;

  always_ff @(posedge clk) begin
    if (ce) a2_1_r <= asq_w[32:0];
  end

  logic signed [15:0] m_x, m_y, m_z;
  assign m_x = in_tdata[15:0];
  assign m_y = in_tdata[31:16];
  assign m_z = in_tdata[47:32];

  // density path
  logic [31:0] ndf_dens;
  logic [31:0] ndf_pdf;

  ggx_ndf u_ndf (
    .clk        (clk),
    .ce         (ce),
    .m_z        (m_z),
    .a2         (a2_1_r),
    .density    (ndf_dens),
    .sample_pdf (ndf_pdf)
  );

  // Smith G1 per direction: wi then wo
  localparam int ZD_LAST = 3 + ggx_pkg::SQRT_STEPS;
  localparam int OK_LAST = ZD_LAST + 1 + ggx_pkg::G1_DIV_STEPS;

  logic [17:0] g1_w [0:1];

  for (genvar d = 0; d < 2; d++) begin : g_dir
    localparam int B = 48 + 48 * d;

    logic signed [15:0] vx, vy, vz;
    logic [16:0]        vabs;
    logic [14:0]        z_w;
    logic [29:0]        zsq_w;

    assign vx    = in_tdata[B +: 16];
    assign vy    = in_tdata[B + 16 +: 16];
    assign vz    = in_tdata[B + 32 +: 16];
    assign vabs  = vz[15] ? (17'd0 - {vz[15], vz}) : {1'b0, vz};
    assign z_w   = (vabs > {2'b0, ggx_pkg::ONE_Q14}) ? ggx_pkg::ONE_Q14 : vabs[14:0];
    assign zsq_w = z_w * z_w;

    // stage 1
    logic signed [31:0] p0_r, p1_r, p2_r;
    logic [14:0]        z1_r;
    logic [28:0]        z2_1_r;
    logic               vneg_r, vzero_r;

    always_ff @(posedge clk) begin
      if (ce) begin
        p0_r    <= vx * m_x;
        p1_r    <= vy * m_y;
        p2_r    <= vz * m_z;
        z1_r    <= z_w;
        z2_1_r  <= zsq_w[28:0];
        vneg_r  <= vz[15];
        vzero_r <= (vz == 16'sd0);
      end
    end

    // stage 2: facing test and alpha term
    logic signed [33:0] dot_w;
    logic [61:0]        pa_w;
    logic [61:0]        pa2_r;
    logic [28:0]        z2_2_r;
    logic [14:0]        z2_r;
    logic               ok2_r;

    assign dot_w = 34'(p0_r) + 34'(p1_r) + 34'(p2_r);
    assign pa_w  = a2_1_r * (ggx_pkg::ONE_Q28 - z2_1_r);

    always_ff @(posedge clk) begin
      if (ce) begin
        pa2_r  <= pa_w;
        z2_2_r <= z2_1_r;
        z2_r   <= z1_r;
        ok2_r  <= (dot_w != 34'sd0) && !vzero_r && (dot_w[33] == vneg_r);
      end
    end

    // stage 3: radicand
    logic [61:0] num3_r;
    logic [14:0] zd_r  [3:ZD_LAST];
    logic        okd_r [3:OK_LAST];

    always_ff @(posedge clk) begin
      if (ce) begin
        num3_r   <= {1'b0, z2_2_r, 32'b0} + pa2_r;
        zd_r[3]  <= z2_r;
        okd_r[3] <= ok2_r;
        for (int k = 4; k <= ZD_LAST; k++) zd_r[k] <= zd_r[k-1];
        for (int k = 4; k <= OK_LAST; k++) okd_r[k] <= okd_r[k-1];
      end
    end

    logic [30:0] root_w;

    ggx_isqrt u_isqrt (
      .clk  (clk),
      .ce   (ce),
      .num  (num3_r),
      .root (root_w)
    );

    // stage after the root: divisor and first partial remainder
    logic [31:0] den_r;
    logic [31:0] r0_r;

    always_ff @(posedge clk) begin
      if (ce) begin
        den_r <= {1'b0, zd_r[ZD_LAST], 16'b0} + {1'b0, root_w};
        r0_r  <= {2'b0, zd_r[ZD_LAST], 15'b0};
      end
    end

    // restoring divider for 2^33 z / (2^16 z + R)
    logic [31:0] r_r   [1:ggx_pkg::G1_DIV_STEPS];
    logic [17:0] q_r   [1:ggx_pkg::G1_DIV_STEPS];
    logic [31:0] den_q [1:ggx_pkg::G1_DIV_STEPS];

    for (genvar k = 1; k <= ggx_pkg::G1_DIV_STEPS; k++) begin : g_div
      logic [31:0] r_p;
      logic [17:0] q_p;
      logic [31:0] den_p;
      logic [32:0] rs;

      if (k == 1) begin : g_first
        assign r_p   = r0_r;
        assign q_p   = '0;
        assign den_p = den_r;
      end else begin : g_next
        assign r_p   = r_r[k-1];
        assign q_p   = q_r[k-1];
        assign den_p = den_q[k-1];
      end

      assign rs = {r_p, 1'b0};

      always_ff @(posedge clk) begin
        if (ce) begin
          if (rs >= {1'b0, den_p}) begin
            r_r[k] <= 32'(rs - {1'b0, den_p});
            q_r[k] <= {q_p[16:0], 1'b1};
          end else begin
            r_r[k] <= rs[31:0];
            q_r[k] <= {q_p[16:0], 1'b0};
          end
          den_q[k] <= den_p;
        end
      end
    end

    assign g1_w[d] = okd_r[OK_LAST] ? q_r[ggx_pkg::G1_DIV_STEPS] : 18'd0;
  end

  // output stage
  logic [35:0] gp_w;
  logic [31:0] dens_o_r;
  logic [31:0] pdf_o_r;
  logic [16:0] shad_o_r;

  assign gp_w = g1_w[0] * g1_w[1];

  always_ff @(posedge clk) begin
    if (ce) begin
      dens_o_r <= ndf_dens;
      pdf_o_r  <= ndf_pdf;
      shad_o_r <= gp_w[32:16];
    end
  end

  assign out_tvalid = vld_r[ggx_pkg::PIPE_DEPTH];
  assign out_tdata  = {7'b0, shad_o_r, pdf_o_r, dens_o_r};

  // checks
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while output stalled");

  a_entry_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[1])
    else $error("accepted item lost at pipe entry");

  a_shadow_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[80:64] <= ggx_pkg::ALPHA_ONE))
    else $error("shadowing above one");

  a_zero_density_pdf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[31:0] == 32'd0)) |-> (out_tdata[63:32] == 32'd0))
    else $error("nonzero pdf with zero density");

endmodule
